>>> sv/ptl_pkg.sv
`default_nettype none

package ptl_pkg;

   localparam int unsigned TICK_W  = 16;
   localparam int unsigned PAIR_W  = 4;
   localparam int unsigned CSR_IDX_W = 2;

   localparam logic [TICK_W-1:0] LONG_TICKS_RST = 16'd5000;
   localparam logic [TICK_W-1:0] HALF_TICKS_RST = 16'd500;
   localparam logic [PAIR_W-1:0] PAIRS_RST      = 4'd5;

   localparam logic [CSR_IDX_W-1:0] CSR_LONG_TICKS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_HALF_TICKS = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PAIRS      = 2'd2;

   typedef enum logic [2:0] {
      PH_GREEN       = 3'd0,
      PH_GREEN_BLINK = 3'd1,
      PH_PREP        = 3'd2,
      PH_RED         = 3'd3,
      PH_RED_BLINK   = 3'd4,
      PH_WALK        = 3'd5,
      PH_WALK_BLINK  = 3'd6
   } phase_type;

   typedef struct packed {
      phase_type          phase;
      logic [TICK_W-1:0]  tick_count;
      logic [PAIR_W-1:0]  pair_count;
      logic [PAIR_W-1:0]  pairs_done;
      logic               blink_on_half;
      logic               request;
   } seq_state_type;

   typedef struct packed {
      logic [TICK_W-1:0] long_phase_ticks;
      logic [TICK_W-1:0] blink_half_ticks;
      logic [PAIR_W-1:0] blink_pairs;
   } cfg_type;

   typedef struct packed {
      logic car_green;
      logic car_yellow;
      logic car_red;
      logic walk_green;
      logic walk_yellow;
      logic walk_red;
   } lamps_type;

endpackage

`default_nettype wire

>>> sv/ptl_req_if.sv
`default_nettype none

interface ptl_req_if;
   logic valid;
   logic ready;
   logic button;

   modport source (output valid, output button, input ready);
   modport sink   (input valid, input button, output ready);
endinterface

`default_nettype wire

>>> sv/ptl_rsp_if.sv
`default_nettype none

interface ptl_rsp_if;
   logic valid;
   logic ready;
   logic car_green;
   logic car_yellow;
   logic car_red;
   logic walk_green;
   logic walk_yellow;
   logic walk_red;

   modport source (output valid, output car_green, output car_yellow, output car_red,
                   output walk_green, output walk_yellow, output walk_red, input ready);
   modport sink   (input valid, input car_green, input car_yellow, input car_red,
                   input walk_green, input walk_yellow, input walk_red, output ready);
endinterface

`default_nettype wire

>>> sv/pedestrian_traffic_light_sequencer.sv
// Pedestrian crossing light sequencer, on-demand walk phase.
// req_if carries one time tick per transfer with the button level sampled
// in that tick. rsp_if returns, for every tick, the six lamp states shown
// during that tick, in order, one result per tick.
// Latency: the result of a tick is valid in the cycle after its transfer.
// Throughput: one tick per cycle when not stalled; the phase, counters and
// request flag are updated in the same cycle that the tick is taken, and
// the lamp values go into a single result register.
// Stall: while rsp_if is stalled the result register holds its value and
// req_if.ready drops; it stays high when the result drains in that cycle.
// Settings are written through csr_we/csr_index/csr_wdata (0: long phase
// ticks, 1: blink half ticks, 2: blink pairs); a write to index 3 is ignored.
// Write them only while no tick is in flight.
// Reset (synchronous, active high): car green phase, counters cleared, no
// request pending, settings 5000 / 500 / 5, result register empty.
`default_nettype none

module pedestrian_traffic_light_sequencer
   import ptl_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [TICK_W-1:0]    csr_wdata,
   ptl_req_if.sink              req_if,
   ptl_rsp_if.source            rsp_if
);

   seq_state_type state_ff;
   seq_state_type state_in;
   cfg_type       cfg_ff;
   lamps_type     lamps;
   logic          rsp_free;
   logic          take;

   assign req_if.ready = rsp_free;
   assign take         = req_if.valid && rsp_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.long_phase_ticks <= LONG_TICKS_RST;
         cfg_ff.blink_half_ticks <= HALF_TICKS_RST;
         cfg_ff.blink_pairs      <= PAIRS_RST;
      end else if (csr_we) begin
         case (csr_index)
            CSR_LONG_TICKS: cfg_ff.long_phase_ticks <= csr_wdata;
            CSR_HALF_TICKS: cfg_ff.blink_half_ticks <= csr_wdata;
            CSR_PAIRS:      cfg_ff.blink_pairs      <= csr_wdata[PAIR_W-1:0];
            default:        cfg_ff <= cfg_ff;
         endcase
      end
   end

   ptl_step u_step (
      .cur    (state_ff),
      .cfg    (cfg_ff),
      .button (req_if.button),
      .nxt    (state_in),
      .lamps  (lamps)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.phase         <= PH_GREEN;
         state_ff.tick_count    <= '0;
         state_ff.pair_count    <= '0;
         state_ff.pairs_done    <= '0;
         state_ff.blink_on_half <= 1'b1;
         state_ff.request       <= 1'b0;
      end else if (take) begin
         state_ff <= state_in;
      end
   end

   ptl_rsp_reg u_rsp_reg (
      .clock    (clock),
      .reset    (reset),
      .load     (take),
      .lamps_in (lamps),
      .free     (rsp_free),
      .rsp      (rsp_if)
   );

   // a latched request is only dropped at the end of the walk blink
   a_request_held: assert property (@(posedge clock) disable iff (reset)
      state_ff.request && (state_ff.phase != PH_WALK_BLINK) |=> state_ff.request)
      else $error("request dropped outside walk blink");

   // exactly one of car green and car red is lit in every result
   a_car_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid |-> $onehot({rsp_if.car_green, rsp_if.car_red}))
      else $error("car green and red not exclusive");

   // walkers only get green behind a car red
   a_walk_safe: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && rsp_if.walk_green |-> rsp_if.car_red && !rsp_if.walk_red)
      else $error("walk green without car red");

endmodule

`default_nettype wire

>>> sv/ptl_step.sv
`default_nettype none

module ptl_step
   import ptl_pkg::*;
(
   input  seq_state_type cur,
   input  cfg_type       cfg,
   input  logic          button,
   output seq_state_type nxt,
   output lamps_type     lamps
);

   logic              req;
   logic [TICK_W-1:0] lp;
   logic [TICK_W-1:0] bh;
   logic [PAIR_W-1:0] bp;
   logic [TICK_W-1:0] dur;
   logic [TICK_W:0]   tick_inc;
   logic [PAIR_W-1:0] pd_inc;
   logic [PAIR_W-1:0] pc_inc;
   logic              y;

   // zero settings behave as one
   assign lp = (cfg.long_phase_ticks == '0) ? TICK_W'(1) : cfg.long_phase_ticks;
   assign bh = (cfg.blink_half_ticks == '0) ? TICK_W'(1) : cfg.blink_half_ticks;
   assign bp = (cfg.blink_pairs == '0) ? PAIR_W'(1) : cfg.blink_pairs;

   assign req      = cur.request | button;
   assign tick_inc = {1'b0, cur.tick_count} + (TICK_W+1)'(1);
   assign pd_inc   = cur.pairs_done + PAIR_W'(1);
   assign pc_inc   = cur.pair_count + PAIR_W'(1);
   assign y        = cur.blink_on_half;

   always_comb begin
      case (cur.phase)
         PH_GREEN, PH_RED, PH_WALK: dur = lp;
         default:                   dur = bh;
      endcase
   end

   // next state
   always_comb begin
      nxt         = cur;
      nxt.request = req;
      if (tick_inc < {1'b0, dur}) begin
         nxt.tick_count = tick_inc[TICK_W-1:0];
      end else begin
         nxt.tick_count = '0;
         case (cur.phase)
            PH_GREEN: begin
               nxt.blink_on_half = 1'b1;
               if (req) begin
                  if (cur.pairs_done >= bp) begin
                     nxt.pairs_done = '0;
                     nxt.pair_count = '0;
                     nxt.phase      = PH_WALK;
                  end else begin
                     nxt.pair_count = cur.pairs_done;
                     nxt.phase      = PH_PREP;
                  end
               end else begin
                  nxt.pairs_done = '0;
                  nxt.phase      = PH_GREEN_BLINK;
               end
            end
            PH_GREEN_BLINK: begin
               if (cur.blink_on_half) begin
                  if (req) begin
                     if (cur.pairs_done >= bp) begin
                        nxt.pairs_done = '0;
                        nxt.pair_count = '0;
                        nxt.phase      = PH_WALK;
                     end else begin
                        nxt.pair_count = cur.pairs_done;
                        nxt.phase      = PH_PREP;
                     end
                  end else begin
                     nxt.blink_on_half = 1'b0;
                  end
               end else begin
                  nxt.blink_on_half = 1'b1;
                  nxt.pairs_done    = pd_inc;
                  if (req) begin
                     if (pd_inc >= bp) begin
                        nxt.pairs_done = '0;
                        nxt.pair_count = '0;
                        nxt.phase      = PH_WALK;
                     end else begin
                        nxt.pair_count = pd_inc;
                        nxt.phase      = PH_PREP;
                     end
                  end else if (pd_inc >= bp) begin
                     nxt.pairs_done = '0;
                     nxt.phase      = PH_RED;
                  end
               end
            end
            PH_PREP, PH_WALK_BLINK: begin
               if (cur.blink_on_half) begin
                  nxt.blink_on_half = 1'b0;
               end else begin
                  nxt.blink_on_half = 1'b1;
                  nxt.pair_count    = pc_inc;
                  if (pc_inc >= bp) begin
                     nxt.pairs_done = '0;
                     nxt.pair_count = '0;
                     if (cur.phase == PH_PREP) begin
                        nxt.phase = PH_WALK;
                     end else begin
                        nxt.request = 1'b0;
                        nxt.phase   = PH_GREEN;
                     end
                  end
               end
            end
            PH_RED: begin
               nxt.blink_on_half = 1'b1;
               nxt.pair_count    = '0;
               if (req) begin
                  nxt.pairs_done = '0;
                  nxt.phase      = PH_WALK;
               end else begin
                  nxt.phase = PH_RED_BLINK;
               end
            end
            PH_RED_BLINK: begin
               if (cur.blink_on_half) begin
                  if (req) begin
                     nxt.pairs_done = '0;
                     nxt.pair_count = '0;
                     nxt.phase      = PH_WALK;
                  end else begin
                     nxt.blink_on_half = 1'b0;
                  end
               end else begin
                  nxt.blink_on_half = 1'b1;
                  nxt.pair_count    = pc_inc;
                  if (req) begin
                     nxt.pairs_done = '0;
                     nxt.pair_count = '0;
                     nxt.phase      = PH_WALK;
                  end else if (pc_inc >= bp) begin
                     nxt.pair_count = '0;
                     nxt.phase      = PH_GREEN;
                  end
               end
            end
            PH_WALK: begin
               nxt.blink_on_half = 1'b1;
               nxt.pair_count    = '0;
               nxt.phase         = PH_WALK_BLINK;
            end
            default: begin
               nxt.blink_on_half = 1'b1;
               nxt.phase         = PH_GREEN;
            end
         endcase
      end
      // an undefined phase code restarts at car green regardless of timing
      if (cur.phase > PH_WALK_BLINK) begin
         nxt.tick_count    = '0;
         nxt.blink_on_half = 1'b1;
         nxt.pair_count    = cur.pair_count;
         nxt.pairs_done    = cur.pairs_done;
         nxt.phase         = PH_GREEN;
      end
   end

   // lamps for the current tick
   always_comb begin
      lamps = '0;
      case (cur.phase)
         PH_GREEN: lamps.car_green = 1'b1;
         PH_GREEN_BLINK: begin
            lamps.car_green  = 1'b1;
            lamps.car_yellow = y;
         end
         PH_PREP: begin
            lamps.car_green   = 1'b1;
            lamps.walk_red    = 1'b1;
            lamps.car_yellow  = y;
            lamps.walk_yellow = y;
         end
         PH_RED: lamps.car_red = 1'b1;
         PH_RED_BLINK: begin
            lamps.car_red    = 1'b1;
            lamps.car_yellow = y;
         end
         PH_WALK: begin
            lamps.car_red    = 1'b1;
            lamps.walk_green = 1'b1;
         end
         PH_WALK_BLINK: begin
            lamps.car_red     = 1'b1;
            lamps.walk_green  = 1'b1;
            lamps.car_yellow  = y;
            lamps.walk_yellow = y;
         end
         default: lamps = '0;
      endcase
   end

endmodule

`default_nettype wire

>>> sv/ptl_rsp_reg.sv
`default_nettype none

module ptl_rsp_reg
   import ptl_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      load,
   input  lamps_type lamps_in,
   output logic      free,
   ptl_rsp_if.source rsp
);

   logic      valid_ff;
   logic      valid_in;
   lamps_type lamps_ff;

   // the register can take a new result when empty or draining this cycle
   assign free     = !valid_ff || rsp.ready;
   assign valid_in = load || (valid_ff && !rsp.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         lamps_ff <= lamps_in;
      end
   end

   assign rsp.valid       = valid_ff;
   assign rsp.car_green   = lamps_ff.car_green;
   assign rsp.car_yellow  = lamps_ff.car_yellow;
   assign rsp.car_red     = lamps_ff.car_red;
   assign rsp.walk_green  = lamps_ff.walk_green;
   assign rsp.walk_yellow = lamps_ff.walk_yellow;
   assign rsp.walk_red    = lamps_ff.walk_red;

endmodule

`default_nettype wire
